// File: rtl/sha512_pkg.sv
// shared types, constants and round constant table for the sha-512 engine
package sha512_pkg;

  localparam int unsigned WordW   = 64;
  localparam int unsigned Rounds  = 80;
  localparam int unsigned BufDep  = 16;
  localparam int unsigned InDataW = 72;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_APPEND,
    OP_LEFT,
    OP_PAD,
    OP_LEN,
    OP_ZLEN,
    OP_CSTART,
    OP_ROUND,
    OP_FOLD,
    OP_RESET
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [2:0] word_sel;
  } cmd_t;

  typedef struct packed {
    logic wrap;
    logic last;
    logic pad2;
    logic rounds_last;
  } stat_t;

  localparam logic [WordW-1:0] IV [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
    64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
    64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  localparam logic [WordW-1:0] K [Rounds] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f,
    64'he9b5dba58189dbbc, 64'h3956c25bf348b538, 64'h59f111f1b605d019,
    64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118, 64'hd807aa98a3030242,
    64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235,
    64'hc19bf174cf692694, 64'he49b69c19ef14ad2, 64'hefbe4786384f25e3,
    64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65, 64'h2de92c6f592b0275,
    64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f,
    64'hbf597fc7beef0ee4, 64'hc6e00bf33da88fc2, 64'hd5a79147930aa725,
    64'h06ca6351e003826f, 64'h142929670a0e6e70, 64'h27b70a8546d22ffc,
    64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6,
    64'h92722c851482353b, 64'ha2bfe8a14cf10364, 64'ha81a664bbc423001,
    64'hc24b8b70d0f89791, 64'hc76c51a30654be30, 64'hd192e819d6ef5218,
    64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99,
    64'h34b0bcb5e19b48a8, 64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb,
    64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3, 64'h748f82ee5defb2fc,
    64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915,
    64'hc67178f2e372532b, 64'hca273eceea26619c, 64'hd186b8c721c0c207,
    64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178, 64'h06f067aa72176fba,
    64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc,
    64'h431d67c49c100d4c, 64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a,
    64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

endpackage

// File: rtl/sha512_ctrl.sv
// sequencer for loading, padding, compression and digest output
module sha512_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic                 m_tlast,
  input  sha512_pkg::stat_t    stat,
  output sha512_pkg::cmd_t     cmd
);
  import sha512_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_APPEND = 10'b0000000010,
    S_CST    = 10'b0000000100,
    S_RND    = 10'b0000001000,
    S_FOLD   = 10'b0000010000,
    S_LEFT   = 10'b0000100000,
    S_PAD    = 10'b0001000000,
    S_LEN    = 10'b0010000000,
    S_ZLEN   = 10'b0100000000,
    S_OUT    = 10'b1000000000
  } state_t;

  typedef enum logic [1:0] {
    R_LEFT,
    R_ZLEN,
    R_OUT
  } ret_t;

  state_t     state, state_next;
  ret_t       ret, ret_next;
  logic [2:0] idx, idx_next;

  always_comb begin
    state_next  = state;
    ret_next    = ret;
    idx_next    = idx;
    cmd.op      = OP_NONE;
    cmd.word_sel = idx;
    s_tready    = 1'b0;
    m_tvalid    = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.op     = OP_LOAD;
          state_next = S_APPEND;
        end
      end
      S_APPEND: begin
        cmd.op = OP_APPEND;
        if (stat.wrap) begin
          ret_next   = R_LEFT;
          state_next = S_CST;
        end else if (stat.last) begin
          state_next = S_PAD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_CST: begin
        cmd.op     = OP_CSTART;
        state_next = S_RND;
      end
      S_RND: begin
        cmd.op = OP_ROUND;
        if (stat.rounds_last) state_next = S_FOLD;
      end
      S_FOLD: begin
        cmd.op = OP_FOLD;
        unique case (ret)
          R_LEFT:  state_next = S_LEFT;
          R_ZLEN:  state_next = S_ZLEN;
          R_OUT:   state_next = S_OUT;
          default: state_next = S_IDLE;
        endcase
      end
      S_LEFT: begin
        cmd.op     = OP_LEFT;
        state_next = stat.last ? S_PAD : S_IDLE;
      end
      S_PAD: begin
        cmd.op = OP_PAD;
        if (stat.pad2) begin
          ret_next   = R_ZLEN;
          state_next = S_CST;
        end else begin
          state_next = S_LEN;
        end
      end
      S_LEN: begin
        cmd.op     = OP_LEN;
        ret_next   = R_OUT;
        state_next = S_CST;
      end
      S_ZLEN: begin
        cmd.op     = OP_ZLEN;
        ret_next   = R_OUT;
        state_next = S_CST;
      end
      S_OUT: begin
        m_tvalid = 1'b1;
        if (m_tready) begin
          if (idx == 3'd7) begin
            cmd.op     = OP_RESET;
            idx_next   = 3'd0;
            state_next = S_IDLE;
          end else begin
            idx_next = idx + 3'd1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign m_tlast = (idx == 3'd7);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= R_LEFT;
      idx   <= 3'd0;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      idx   <= idx_next;
    end
  end
endmodule

// File: rtl/sha512_dp.sv
// block buffer, message schedule, round unit, hash state and bit count
module sha512_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [sha512_pkg::InDataW-1:0]    in_data,
  input  logic                              in_last,
  input  sha512_pkg::cmd_t                  cmd,
  output sha512_pkg::stat_t                 stat,
  output logic [sha512_pkg::WordW-1:0]      digest
);
  import sha512_pkg::*;

  logic [WordW-1:0] buf_w [BufDep];
  logic [WordW-1:0] w     [BufDep];
  logic [WordW-1:0] v     [8];
  logic [WordW-1:0] hash  [8];
  logic [WordW-1:0] din;
  logic [3:0]       dn;
  logic             dlast;
  logic [6:0]       fill;
  logic [127:0]     total;
  logic [6:0]       rnd;

  logic [2:0]       o;
  logic [3:0]       idx, idx_nx;
  logic [7:0]       sum;
  logic [127:0]     shifted;
  logic [WordW-1:0] keep, padbyte;
  logic [WordW-1:0] s0, s1, wnew, bs1, bs0, ch, maj, t1, t2;

  assign o       = fill[2:0];
  assign idx     = fill[6:3];
  assign idx_nx  = idx + 4'd1;
  assign sum     = {1'b0, fill} + {4'd0, dn};
  assign shifted = {din, 64'd0} >> {o, 3'b000};
  assign keep    = ~({WordW{1'b1}} >> {o, 3'b000});
  assign padbyte = {8'h80, 56'd0} >> {o, 3'b000};

  assign stat.wrap        = sum[7];
  assign stat.last        = dlast;
  assign stat.pad2        = (fill[6:4] == 3'b111);
  assign stat.rounds_last = (rnd == 7'(Rounds - 1));

  assign digest = hash[cmd.word_sel];

  // schedule and round logic
  assign s0   = {w[1][0], w[1][63:1]} ^ {w[1][7:0], w[1][63:8]} ^ (w[1] >> 7);
  assign s1   = {w[14][18:0], w[14][63:19]} ^ {w[14][60:0], w[14][63:61]} ^ (w[14] >> 6);
  assign wnew = s1 + w[9] + s0 + w[0];
  assign bs1  = {v[4][13:0], v[4][63:14]} ^ {v[4][17:0], v[4][63:18]}
              ^ {v[4][40:0], v[4][63:41]};
  assign ch   = (v[4] & v[5]) ^ (~v[4] & v[6]);
  assign t1   = v[7] + bs1 + ch + K[rnd] + w[0];
  assign bs0  = {v[0][27:0], v[0][63:28]} ^ {v[0][33:0], v[0][63:34]}
              ^ {v[0][38:0], v[0][63:39]};
  assign maj  = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
  assign t2   = bs0 + maj;

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        din   <= in_data[63:0];
        dn    <= in_data[67] ? 4'd8 : in_data[67:64];
        dlast <= in_last;
      end
      OP_APPEND: begin
        buf_w[idx] <= (buf_w[idx] & keep) | shifted[127:64];
        if (!sum[7] && idx != 4'd15) buf_w[idx_nx] <= shifted[63:0];
      end
      OP_LEFT: buf_w[0] <= shifted[63:0];
      OP_PAD: begin
        for (int j = 0; j < BufDep; j++) begin
          if (4'(j) > idx) buf_w[j] <= '0;
        end
        buf_w[idx] <= (buf_w[idx] & keep) | padbyte;
      end
      OP_LEN: begin
        buf_w[14] <= total[127:64];
        buf_w[15] <= total[63:0];
      end
      OP_ZLEN: begin
        for (int j = 0; j < BufDep - 2; j++) buf_w[j] <= '0;
        buf_w[14] <= total[127:64];
        buf_w[15] <= total[63:0];
      end
      OP_CSTART: begin
        for (int j = 0; j < BufDep; j++) w[j] <= buf_w[j];
        for (int j = 0; j < 8; j++) v[j] <= hash[j];
      end
      OP_ROUND: begin
        for (int j = 0; j < BufDep - 1; j++) w[j] <= w[j + 1];
        w[15] <= wnew;
        v[7] <= v[6];
        v[6] <= v[5];
        v[5] <= v[4];
        v[4] <= v[3] + t1;
        v[3] <= v[2];
        v[2] <= v[1];
        v[1] <= v[0];
        v[0] <= t1 + t2;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < 8; j++) hash[j] <= IV[j];
      fill  <= '0;
      total <= '0;
      rnd   <= '0;
    end else begin
      case (cmd.op)
        OP_APPEND: if (!sum[7]) fill <= sum[6:0];
        OP_LEFT: begin
          fill  <= sum[6:0];
          total <= total + 128'd1024;
        end
        OP_PAD:    total <= total + {118'd0, fill, 3'b000};
        OP_CSTART: rnd <= '0;
        OP_ROUND:  rnd <= rnd + 7'd1;
        OP_FOLD:   for (int j = 0; j < 8; j++) hash[j] <= hash[j] + v[j];
        OP_RESET: begin
          for (int j = 0; j < 8; j++) hash[j] <= IV[j];
          fill  <= '0;
          total <= '0;
        end
        default: ;
      endcase
    end
  end
endmodule

// File: rtl/sha512_hash_engine_unit.sv
// sha-512 engine top level: sequencer plus datapath
//
// channel  dir  tdata                                  tuser       tlast
// s_       in   data_word[63:0] byte_count[67:64]      -           last_word
// m_       out  digest_word[63:0]                      word_index  last_result
//
// a word is taken in by a load step and an append step; each full 128-byte block is
// load, 80 rounds at one round per cycle, fold, leftover, all in the single round unit
// a final word adds padding steps and one or two block compressions, then 8 beats
// synchronous reset restores the initial hash, count and fill at once
// input is held off while a block compresses or a digest beat waits
module sha512_hash_engine_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,  // data_word[63:0], byte_count[67:64], zero
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,  // digest_word[63:0]
  output logic [2:0]  m_tuser,  // word_index[2:0]
  output logic        m_tlast
);
  import sha512_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  sha512_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast),
    .stat     (stat),
    .cmd      (cmd)
  );

  sha512_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .in_data (s_tdata),
    .in_last (s_tlast),
    .cmd     (cmd),
    .stat    (stat),
    .digest  (m_tdata)
  );

  assign m_tuser = cmd.word_sel;

  a_excl: assert property (@(posedge clk) disable iff (rst) m_tvalid |-> !s_tready)
    else $error("input ready while digest pending");
  a_accept: assert property (@(posedge clk) disable iff (rst)
      s_tvalid && s_tready |=> !s_tready && !m_tvalid)
    else $error("no work cycle after accept");
  a_end: assert property (@(posedge clk) disable iff (rst)
      m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
    else $error("not idle after final digest beat");
  a_idx: assert property (@(posedge clk) disable iff (rst)
      m_tvalid |-> (m_tlast == (m_tuser == 3'd7)))
    else $error("last flag and word index disagree");
endmodule

// File: tb/sv/tb_sha512_hash_engine_unit.sv
// self-checking testbench for the sha-512 hash engine: directed and random messages
module tb_sha512_hash_engine_unit;
  import sha512_pkg::*;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [71:0] s_tdata;  // data_word[63:0], byte_count[67:64], zero
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;  // digest_word[63:0]
  logic [2:0]  m_tuser;  // word_index[2:0]
  logic        m_tlast;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [2:0]  word_index;
    logic        last_result;
  } digest_beat_t;

  sha512_hash_engine_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  // predictor state
  logic [63:0]  hv [8];
  logic [63:0]  blk [16];
  int unsigned  fill;
  logic [127:0] bit_total;
  digest_beat_t digest_q [$];

  int  mism;
  int  fail_cnt;
  int  items_sent;
  bit  sink_idle_ok;
  int  sink_hold;
  bit  send_idle_ok;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic logic [63:0] rotr64(logic [63:0] x, int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  function automatic void hash_restart();
    for (int i = 0; i < 8; i++) hv[i] = IV[i];
    fill = 0;
    bit_total = '0;
  endfunction

  function automatic void compress_block();
    logic [63:0] w [80];
    logic [63:0] v [8];
    logic [63:0] s0, s1, t1, t2;
    for (int i = 0; i < 16; i++) w[i] = blk[i];
    for (int i = 16; i < 80; i++) begin
      s0 = rotr64(w[i-15], 1) ^ rotr64(w[i-15], 8) ^ (w[i-15] >> 7);
      s1 = rotr64(w[i-2], 19) ^ rotr64(w[i-2], 61) ^ (w[i-2] >> 6);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    for (int i = 0; i < 8; i++) v[i] = hv[i];
    for (int i = 0; i < 80; i++) begin
      t1 = v[7] + (rotr64(v[4], 14) ^ rotr64(v[4], 18) ^ rotr64(v[4], 41))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K[i] + w[i];
      t2 = (rotr64(v[0], 28) ^ rotr64(v[0], 34) ^ rotr64(v[0], 39))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hv[i] += v[i];
  endfunction

  function automatic void set_byte(int unsigned pos, logic [7:0] b);
    blk[(pos >> 3) & 15][56 - 8*(pos & 7) +: 8] = b;
  endfunction

  function automatic void predict_word(logic [63:0] data, logic [3:0] cnt, logic lst);
    int unsigned n;
    digest_beat_t b;
    n = (cnt > 8) ? 8 : cnt;
    for (int i = 0; i < n; i++) begin
      set_byte(fill, data[56 - 8*i +: 8]);
      fill++;
      if (fill == 128) begin
        compress_block();
        bit_total += 128'd1024;
        fill = 0;
      end
    end
    if (!lst) return;
    bit_total += 128'(fill * 8);
    set_byte(fill, 8'h80);
    for (int i = fill + 1; i < 128; i++) set_byte(i, 8'h00);
    if (fill >= 112) begin
      compress_block();
      for (int i = 0; i < 16; i++) blk[i] = '0;
    end
    blk[14] = bit_total[127:64];
    blk[15] = bit_total[63:0];
    compress_block();
    for (int i = 0; i < 8; i++) begin
      b.digest_word = hv[i];
      b.word_index  = 3'(i);
      b.last_result = (i == 7);
      digest_q.push_back(b);
    end
    hash_restart();
  endfunction

  task automatic send_word(logic [63:0] data, logic [3:0] cnt, logic lst);
    if (send_idle_ok) begin
      while ($urandom_range(99) < 28) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, cnt, data};
    s_tlast  <= lst;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_word(data, cnt, lst);
    items_sent++;
  endtask

  task automatic send_message(int unsigned nbytes, bit odd_counts);
    int unsigned left;
    int unsigned c;
    left = nbytes;
    while (left > 8) begin
      c = 8;
      if (odd_counts && $urandom_range(9) == 0) c = $urandom_range(15);
      if (c > left) c = left;
      send_word({$urandom, $urandom}, 4'(c), 1'b0);
      left -= (c > 8) ? 8 : c;
    end
    send_word({$urandom, $urandom}, 4'(left), 1'b1);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_word(64'h0, 4'd0, 1'b1);
    send_word(64'h6162630000000000, 4'd3, 1'b1);
    send_word(64'hffffffffffffffff, 4'd8, 1'b1);
    send_word(64'h0, 4'd8, 1'b1);
    send_word(64'hffffffffffffffff, 4'd15, 1'b1);
    send_word(64'h0123456789abcdef, 4'd9, 1'b0);
    send_word(64'hfedcba9876543210, 4'd5, 1'b0);
    send_word(64'h5555aaaa5555aaaa, 4'd0, 1'b0);
    send_word(64'haaaa5555aaaa5555, 4'd2, 1'b1);
    wait_drained();
  endtask

  task automatic test_pad_boundaries();
    send_message(111, 0);
    send_message(112, 0);
    send_message(127, 0);
    send_message(128, 0);
    send_message(129, 0);
    wait_drained();
  endtask

  task automatic test_random_messages();
    while (items_sent < 250) begin
      case ($urandom_range(3))
        0: send_message($urandom_range(16), 1);
        1: send_message($urandom_range(300), 1);
        default: send_message($urandom_range(140), 0);
      endcase
    end
  endtask

  task automatic test_backpressure();
    send_idle_ok = 0;
    sink_hold = 400;
    send_message(200, 0);
    send_message(40, 0);
    send_message(9, 0);
    wait_drained();
    send_idle_ok = 1;
  endtask

  task automatic test_no_idle_stretch();
    send_idle_ok = 0;
    sink_idle_ok = 0;
    repeat (4) send_message($urandom_range(200), 1);
    wait_drained();
    send_idle_ok = 1;
    sink_idle_ok = 1;
  endtask

  // receiver readiness
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= !sink_idle_ok || ($urandom_range(99) >= 28);
    end
  end

  // result checker
  always @(posedge clk) begin
    digest_beat_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (digest_q.size() == 0) begin
        fail_cnt++;
        if (mism < 10) $display("unexpected digest beat %h", m_tdata);
        mism++;
      end else begin
        e = digest_q.pop_front();
        if (e.digest_word !== m_tdata || e.word_index !== m_tuser ||
            e.last_result !== m_tlast) begin
          fail_cnt++;
          if (mism < 10)
            $display("digest mismatch exp %h/%0d/%b got %h/%0d/%b", e.digest_word,
                     e.word_index, e.last_result, m_tdata, m_tuser, m_tlast);
          mism++;
        end
      end
    end
  end

  initial begin
    #4000000;
    $display("tb_sha512_hash_engine_unit: errors");
    $finish;
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    mism = 0;
    fail_cnt = 0;
    items_sent = 0;
    sink_idle_ok = 1;
    send_idle_ok = 1;
    sink_hold = 0;
    hash_restart();
    for (int i = 0; i < 16; i++) blk[i] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_pad_boundaries();
    test_backpressure();
    test_no_idle_stretch();
    test_random_messages();
    wait_drained();
    repeat (200) @(posedge clk);
    if (fail_cnt == 0 && digest_q.size() == 0)
      $display("tb_sha512_hash_engine_unit: clean");
    else
      $display("tb_sha512_hash_engine_unit: errors");
    $finish;
  end

endmodule
